>>> design/gsl_pkg.sv
// Shared types and constants for the golden-section line search unit.
// No dependencies; imported by gsl_golden_pt and golden_section_line_search_unit.
`default_nettype none

package gsl_pkg;

  // Search phase: which point the next error measurement belongs to
  typedef enum logic [1:0] {
    PH_WAIT_A = 2'd0,
    PH_WAIT_D = 2'd1,
    PH_WAIT_C = 2'd2,
    PH_WAIT_B = 2'd3
  } phase_t;

  // 1/phi as an unsigned Q0.32 fraction
  localparam logic [31:0] INV_PHI_Q32 = 32'h9E3779B9;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_STEP_LOW     = 2'd0;
  localparam logic [1:0] REG_STEP_HIGH    = 2'd1;
  localparam logic [1:0] REG_STOP_GAP     = 2'd2;
  localparam logic [1:0] REG_SEARCH_TOTAL = 2'd3;

  // Reset values of the registers
  localparam logic [31:0] STEP_LOW_RST     = 32'd0;
  localparam logic [31:0] STEP_HIGH_RST    = 32'd4294967;
  localparam logic [31:0] STOP_GAP_RST     = 32'd4295;
  localparam logic [15:0] SEARCH_TOTAL_RST = 16'd1000;

  // Result kinds
  localparam logic KIND_EVAL = 1'b0;
  localparam logic KIND_MOVE = 1'b1;

endpackage : gsl_pkg

`default_nettype wire

>>> design/gsl_golden_pt.sv
// Golden-ratio interior point lo + floor((hi - lo) / phi), truncated.
// Depends on gsl_pkg for the 1/phi constant.
`default_nettype none

module gsl_golden_pt #(
  parameter int STEP_BITS = 32
) (
  input  wire logic [STEP_BITS-1:0] lo,
  input  wire logic [STEP_BITS-1:0] hi,
  output logic      [STEP_BITS-1:0] pt
);
  import gsl_pkg::*;

  localparam int PROD_W = STEP_BITS + 32;

  logic [STEP_BITS-1:0] span;
  logic [PROD_W-1:0]    prod;

  // Reversed bracket counts as an empty span
  assign span = (hi > lo) ? (hi - lo) : '0;
  assign prod = PROD_W'(span) * PROD_W'(INV_PHI_Q32);
  assign pt   = lo + prod[PROD_W-1:32];

endmodule : gsl_golden_pt

`default_nettype wire

>>> design/golden_section_line_search_unit.sv
// Top level of the golden-section line search unit: request channels,
// configuration registers, search state and result register.
// Depends on gsl_pkg and gsl_golden_pt.
`default_nettype none

// Each search starts with the error measured at step_low. Every accepted
// error request answers with exactly one result request: either an evaluate
// request (result_kind 0) for the next step to measure - step_high, then the
// two golden-ratio interior points, then one new interior point per narrowing
// round - or, once the interior gap is no larger than stop_gap, a move
// (result_kind 1) to the first of the four bracket points whose error is no
// greater than the others. all_done flags the move that completes search
// number search_total, after which the count restarts. The unit takes one
// request per cycle while results are taken, passing an input register, then one
// pass of logic into the result register. The longest path is the error
// compare that picks the bracket end, followed by the span subtract, the
// STEP_BITS x 32 multiply by 1/phi and the final add. step_low and step_high
// are sampled when a search starts; stop_gap is read at every gap test.
// Configuration writes are expected only while the unit is idle.

module golden_section_line_search_unit #(
  parameter int STEP_BITS  = 32,
  parameter int ERROR_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // error measurement requests
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [ERROR_BITS-1:0] in_measured_error,
  // evaluate / move results
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [STEP_BITS-1:0]  out_step_value,
  output logic                       out_result_kind,
  output logic                       out_all_done,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [3:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);
  import gsl_pkg::*;

  localparam int GAP_W = (STEP_BITS > 32) ? STEP_BITS : 32;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [STEP_BITS-1:0] step_low_r, step_high_r;
  logic [31:0]          stop_gap_r;
  logic [15:0]          search_total_r;
  logic                 cfg_wr;
  logic [1:0]           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_low_r     <= STEP_BITS'(STEP_LOW_RST);
      step_high_r    <= STEP_BITS'(STEP_HIGH_RST);
      stop_gap_r     <= STOP_GAP_RST;
      search_total_r <= SEARCH_TOTAL_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_STEP_LOW:     step_low_r     <= STEP_BITS'(pwdata);
        REG_STEP_HIGH:    step_high_r    <= STEP_BITS'(pwdata);
        REG_STOP_GAP:     stop_gap_r     <= pwdata;
        REG_SEARCH_TOTAL: search_total_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back: widen or cut to the 32-bit bus
  always_comb begin
    case (cfg_idx)
      REG_STEP_LOW:     prdata = 32'(step_low_r);
      REG_STEP_HIGH:    prdata = 32'(step_high_r);
      REG_STOP_GAP:     prdata = stop_gap_r;
      REG_SEARCH_TOTAL: prdata = {16'd0, search_total_r};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register and result register handshake
  // ---------------------------------------------------------------------------
  logic                  inq_valid_r;
  logic [ERROR_BITS-1:0] inq_err_r;
  logic                  out_valid_r;
  logic                  adv;

  // Advance when an error is held and the result slot is free or being taken
  assign adv      = inq_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !inq_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) inq_valid_r <= in_valid;
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) inq_err_r <= in_measured_error;
  end

  // ---------------------------------------------------------------------------
  // Search state
  // ---------------------------------------------------------------------------
  phase_t                phase_r, phase_nxt;
  logic                  refining_r, refining_nxt;
  logic [STEP_BITS-1:0]  a_step_r, b_step_r, c_step_r, d_step_r;
  logic [STEP_BITS-1:0]  a_step_nxt, b_step_nxt, c_step_nxt, d_step_nxt;
  logic [ERROR_BITS-1:0] a_err_r, b_err_r, c_err_r, d_err_r;
  logic [ERROR_BITS-1:0] a_err_nxt, b_err_nxt, c_err_nxt, d_err_nxt;
  logic [15:0]           searches_r, searches_nxt;

  // Errors of B and C as seen in this round (fresh measurement wins)
  logic [ERROR_BITS-1:0] b_err_eff, c_err_eff;
  logic                  narrowing, drop_a, gap_ok, move;
  logic [STEP_BITS-1:0]  c_gap;
  logic [15:0]           count;
  logic                  last_search;
  logic [STEP_BITS-1:0]  g_lo, g_hi, g_pt;

  logic [STEP_BITS-1:0]  step_res;
  logic                  kind_res, done_res;

  assign narrowing = (phase_r == PH_WAIT_B) || ((phase_r == PH_WAIT_C) && refining_r);
  assign b_err_eff = (phase_r == PH_WAIT_B) ? inq_err_r : b_err_r;
  assign c_err_eff = (phase_r == PH_WAIT_C) ? inq_err_r : c_err_r;
  assign c_gap     = (c_step_r > b_step_r) ? (c_step_r - b_step_r) : '0;
  assign gap_ok    = GAP_W'(c_gap) <= GAP_W'(stop_gap_r);
  assign drop_a    = b_err_eff > c_err_eff;
  assign move      = narrowing && gap_ok;

  assign count       = searches_r + 16'd1;
  assign last_search = count >= search_total_r;

  // Pick the bracket whose interior point is asked for next
  always_comb begin
    g_lo = a_step_r;
    g_hi = d_step_r;
    if (narrowing) begin
      if (drop_a) begin
        g_lo = b_step_r;
      end else begin
        g_hi = b_step_r;
      end
    end else if (phase_r == PH_WAIT_C) begin
      g_hi = c_step_r;
    end
  end

  gsl_golden_pt #(
    .STEP_BITS (STEP_BITS)
  ) u_golden (
    .lo (g_lo),
    .hi (g_hi),
    .pt (g_pt)
  );

  // Next phase
  always_comb begin
    case (phase_r)
      PH_WAIT_A: phase_nxt = PH_WAIT_D;
      PH_WAIT_D: phase_nxt = PH_WAIT_C;
      PH_WAIT_C,
      PH_WAIT_B: begin
        if (!narrowing) begin
          phase_nxt = PH_WAIT_B;
        end else if (move) begin
          phase_nxt = PH_WAIT_A;
        end else if (drop_a) begin
          phase_nxt = PH_WAIT_C;
        end else begin
          phase_nxt = PH_WAIT_B;
        end
      end
      default: phase_nxt = PH_WAIT_A;
    endcase
  end

  // Bracket update and result
  always_comb begin
    a_step_nxt   = a_step_r;
    b_step_nxt   = b_step_r;
    c_step_nxt   = c_step_r;
    d_step_nxt   = d_step_r;
    a_err_nxt    = a_err_r;
    b_err_nxt    = b_err_r;
    c_err_nxt    = c_err_r;
    d_err_nxt    = d_err_r;
    refining_nxt = refining_r;
    searches_nxt = searches_r;
    step_res     = g_pt;
    kind_res     = KIND_EVAL;
    done_res     = 1'b0;
    case (phase_r)
      PH_WAIT_A: begin
        a_err_nxt    = inq_err_r;
        a_step_nxt   = step_low_r;
        d_step_nxt   = step_high_r;
        refining_nxt = 1'b0;
        step_res     = step_high_r;
      end
      PH_WAIT_D: begin
        d_err_nxt  = inq_err_r;
        c_step_nxt = g_pt;
      end
      PH_WAIT_C,
      PH_WAIT_B: begin
        b_err_nxt = b_err_eff;
        c_err_nxt = c_err_eff;
        if (!narrowing) begin
          b_step_nxt = g_pt;
        end else if (gap_ok) begin
          // Move to the first point whose error is no greater than the rest
          refining_nxt = 1'b0;
          kind_res     = KIND_MOVE;
          done_res     = last_search;
          searches_nxt = last_search ? 16'd0 : count;
          if (a_err_r <= b_err_eff && a_err_r <= c_err_eff && a_err_r <= d_err_r) begin
            step_res = a_step_r;
          end else if (b_err_eff <= a_err_r && b_err_eff <= c_err_eff &&
                       b_err_eff <= d_err_r) begin
            step_res = b_step_r;
          end else if (c_err_eff <= a_err_r && c_err_eff <= b_err_eff &&
                       c_err_eff <= d_err_r) begin
            step_res = c_step_r;
          end else begin
            step_res = d_step_r;
          end
        end else if (drop_a) begin
          // Drop A: shift B into A, C into B, ask for a new C
          refining_nxt = 1'b1;
          a_step_nxt   = b_step_r;
          a_err_nxt    = b_err_eff;
          b_step_nxt   = c_step_r;
          b_err_nxt    = c_err_eff;
          c_step_nxt   = g_pt;
        end else begin
          // Drop D: shift C into D, B into C, ask for a new B
          refining_nxt = 1'b1;
          d_step_nxt   = c_step_r;
          d_err_nxt    = c_err_eff;
          c_step_nxt   = b_step_r;
          c_err_nxt    = b_err_eff;
          b_step_nxt   = g_pt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_WAIT_A;
      refining_r <= 1'b0;
      searches_r <= '0;
      a_step_r   <= '0;
      b_step_r   <= '0;
      c_step_r   <= '0;
      d_step_r   <= '0;
      a_err_r    <= '0;
      b_err_r    <= '0;
      c_err_r    <= '0;
      d_err_r    <= '0;
    end else if (adv) begin
      phase_r    <= phase_nxt;
      refining_r <= refining_nxt;
      searches_r <= searches_nxt;
      a_step_r   <= a_step_nxt;
      b_step_r   <= b_step_nxt;
      c_step_r   <= c_step_nxt;
      d_step_r   <= d_step_nxt;
      a_err_r    <= a_err_nxt;
      b_err_r    <= b_err_nxt;
      c_err_r    <= c_err_nxt;
      d_err_r    <= d_err_nxt;
    end
  end

  // Result register: hold while the consumer stalls
  logic [STEP_BITS-1:0] out_step_r;
  logic                 out_kind_r, out_done_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_step_r <= step_res;
      out_kind_r <= kind_res;
      out_done_r <= done_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_step_value  = out_step_r;
  assign out_result_kind = out_kind_r;
  assign out_all_done    = out_done_r;

`ifndef SYNTHESIS
  // The done flag only ever rides on a move
  a_done_on_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_kind_r == KIND_MOVE)
    else $error("all_done raised on an evaluate request");

  // A move always returns the search to waiting for the low end error
  a_move_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    adv && move |=> phase_r == PH_WAIT_A && !refining_r)
    else $error("search did not restart after a move");

  // Narrowing rounds only live in the interior phases
  a_refining_phase: assert property (@(posedge clk) disable iff (!rst_n)
    refining_r |-> (phase_r == PH_WAIT_C || phase_r == PH_WAIT_B))
    else $error("refining set outside the interior phases");

  // A held error with a stalled result must block new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    inq_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("request accepted while both registers are full");
`endif

endmodule : golden_section_line_search_unit

`default_nettype wire

>>> sim/tb_golden_section_line_search_unit.sv
// Self-checking testbench for golden_section_line_search_unit: error requests in, evaluate and
// move requests out, APB-style register port. Depends on gsl_pkg and the unit's RTL only.
// A built-in search predictor forms the expected result for every accepted error request.
`timescale 1ns / 100ps

module tb_golden_section_line_search_unit;
  import gsl_pkg::*;

  // Bound on the whole run
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 12;
  localparam int ERRORS_PER_PHASE = 140;

  typedef struct packed {
    logic [31:0] step;
    logic        kind;
    logic        done;
  } search_answer_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_measured_error;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_step_value;
  logic        out_result_kind;
  logic        out_all_done;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copies of the configuration registers
  logic [31:0] cfg_step_low;
  logic [31:0] cfg_step_high;
  logic [31:0] cfg_stop_gap;
  logic [15:0] cfg_search_total;

  // Predicted search state
  phase_t      srch_phase;
  logic        refining;
  logic [31:0] a_step, b_step, c_step, d_step;
  logic [31:0] a_err, b_err, c_err, d_err;
  logic [15:0] searches_done;
  logic [31:0] probe_at;

  // Shape of the error curve used for the search in progress
  int unsigned err_style;
  logic [31:0] bowl_centre;
  int unsigned bowl_shift;
  logic [31:0] flat_err;

  search_answer_t answers_due[$];
  int             mismatches;
  int unsigned    cycles;
  bit             in_gaps_on;
  bit             out_gaps_on;

  golden_section_line_search_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_measured_error (in_measured_error),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_step_value    (out_step_value),
    .out_result_kind   (out_result_kind),
    .out_all_done      (out_all_done),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, what);
  endtask

  function automatic logic [31:0] sat_diff(input logic [31:0] hi, input logic [31:0] lo);
    return (hi > lo) ? hi - lo : 32'd0;
  endfunction

  // Interior point lo + span/phi, truncated
  function automatic logic [31:0] golden_cut(input logic [31:0] lo, input logic [31:0] hi);
    logic [63:0] prod;
    prod = {32'd0, sat_diff(hi, lo)} * {32'd0, INV_PHI_Q32};
    return lo + prod[63:32];
  endfunction

  // Advance the predicted search by one error measurement and return the result it causes
  function automatic search_answer_t advance_search(input logic [31:0] err);
    search_answer_t ans;
    logic           do_narrow;
    logic [15:0]    count;
    ans = '{step: 32'd0, kind: KIND_EVAL, done: 1'b0};
    do_narrow = 1'b0;
    case (srch_phase)
      PH_WAIT_A: begin
        // step_low and step_high are latched only here
        a_err = err;
        a_step = cfg_step_low;
        d_step = cfg_step_high;
        refining = 1'b0;
        srch_phase = PH_WAIT_D;
        ans.step = d_step;
      end
      PH_WAIT_D: begin
        d_err = err;
        c_step = golden_cut(a_step, d_step);
        srch_phase = PH_WAIT_C;
        ans.step = c_step;
      end
      PH_WAIT_C: begin
        c_err = err;
        if (refining) begin
          do_narrow = 1'b1;
        end else begin
          b_step = golden_cut(a_step, c_step);
          srch_phase = PH_WAIT_B;
          ans.step = b_step;
        end
      end
      default: begin
        b_err = err;
        do_narrow = 1'b1;
      end
    endcase
    if (do_narrow) begin
      refining = 1'b1;
      if (sat_diff(c_step, b_step) <= cfg_stop_gap) begin
        // Move to the first point whose error is no greater than the other three
        if (a_err <= b_err && a_err <= c_err && a_err <= d_err) ans.step = a_step;
        else if (b_err <= a_err && b_err <= c_err && b_err <= d_err) ans.step = b_step;
        else if (c_err <= a_err && c_err <= b_err && c_err <= d_err) ans.step = c_step;
        else ans.step = d_step;
        count = searches_done + 16'd1;
        if (count >= cfg_search_total) begin
          ans.done = 1'b1;
          searches_done = 16'd0;
        end else begin
          searches_done = count;
        end
        srch_phase = PH_WAIT_A;
        refining = 1'b0;
        ans.kind = KIND_MOVE;
      end else if (b_err > c_err) begin
        // Drop A
        a_step = b_step;
        a_err = b_err;
        b_step = c_step;
        b_err = c_err;
        c_step = golden_cut(a_step, d_step);
        srch_phase = PH_WAIT_C;
        ans.step = c_step;
      end else begin
        // Drop D
        d_step = c_step;
        d_err = c_err;
        c_step = b_step;
        c_err = b_err;
        b_step = golden_cut(a_step, c_step);
        srch_phase = PH_WAIT_B;
        ans.step = b_step;
      end
    end
    probe_at = ans.step;
    return ans;
  endfunction

  // Error at step s under the curve of the current search; pick a new curve at search start
  function automatic logic [31:0] measured_at(input logic [31:0] s);
    logic [31:0] offset;
    logic [63:0] prod;
    if (srch_phase == PH_WAIT_A) begin
      err_style = $urandom_range(0, 9);
      bowl_shift = $urandom_range(0, 31);
      flat_err = $urandom;
      if ($urandom_range(0, 1) == 0) begin
        bowl_centre = $urandom;
      end else begin
        prod = {32'd0, sat_diff(cfg_step_high, cfg_step_low)} * {32'd0, $urandom};
        bowl_centre = cfg_step_low + prod[63:32];
      end
    end
    offset = (s > bowl_centre) ? s - bowl_centre : bowl_centre - s;
    case (err_style)
      6: return ~(offset >> bowl_shift);
      7: return $urandom;
      8: return flat_err;
      9: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
      default: return offset >> bowl_shift;
    endcase
  endfunction

  function automatic int unsigned draw_wait(input bit gaps_on);
    return gaps_on ? $urandom_range(0, 7) : 0;
  endfunction

  // Send one error request; predict its result once it is accepted
  task automatic send_error(input logic [31:0] err);
    int unsigned    w;
    search_answer_t due;
    w = draw_wait(in_gaps_on);
    if (w != 0) begin
      in_valid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_measured_error <= err;
    do @(posedge clk); while (!(in_valid && in_ready === 1'b1));
    due = advance_search(err);
    answers_due.insert(answers_due.size(), due);
    @(negedge clk);
  endtask

  // Drop valid and hold until every expected result has left the unit
  task automatic drain;
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_STEP_LOW:     cfg_step_low = val;
      REG_STEP_HIGH:    cfg_step_high = val;
      REG_STOP_GAP:     cfg_stop_gap = val;
      REG_SEARCH_TOTAL: cfg_search_total = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic reg_check(input logic [1:0] idx);
    logic [31:0] want;
    case (idx)
      REG_STEP_LOW:     want = cfg_step_low;
      REG_STEP_HIGH:    want = cfg_step_high;
      REG_STOP_GAP:     want = cfg_stop_gap;
      default:          want = {16'd0, cfg_search_total};
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== want)
      report_mismatch($sformatf("register %0d read %h, expected %h", idx, prdata, want));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [31:0] low, input logic [31:0] high,
                               input logic [31:0] gap, input logic [15:0] total);
    reg_write(REG_STEP_LOW, low);
    reg_write(REG_STEP_HIGH, high);
    reg_write(REG_STOP_GAP, gap);
    reg_write(REG_SEARCH_TOTAL, {16'd0, total});
  endtask

  // Result side: draw a stall per result, then hold ready until one is taken
  initial begin
    int unsigned w;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      w = draw_wait(out_gaps_on);
      if (w != 0) begin
        out_ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_ready));
      @(negedge clk);
    end
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    search_answer_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready) begin
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result step %h kind %b done %b",
                                  out_step_value, out_result_kind, out_all_done));
      end else begin
        want = answers_due.pop_front();
        if (out_step_value !== want.step || out_result_kind !== want.kind ||
            out_all_done !== want.done)
          report_mismatch($sformatf("result step %h kind %b done %b, expected %h %b %b",
                                    out_step_value, out_result_kind, out_all_done,
                                    want.step, want.kind, want.done));
      end
    end
  end

  // Registers must read back their reset values
  task automatic test_register_reset;
    for (int i = 0; i < 4; i++) reg_check(2'(i));
  endtask

  // With the widest stop gap every search ends after four error measurements; exercise the
  // tie-break, the error extremes and the done flag on the second search
  task automatic test_four_point_searches;
    apply_setting(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd2);
    for (int i = 0; i < 4; i++) reg_check(2'(i));
    // minimum at D
    send_error(32'hFFFF_FFFF);
    send_error(32'd0);
    send_error(32'hFFFF_FFFF);
    send_error(32'hFFFF_FFFF);
    // all equal: first point wins, and this move completes the run
    repeat (4) send_error(32'd5);
    // B and C tie below A and D: B wins
    send_error(32'd9);
    send_error(32'd9);
    send_error(32'd3);
    send_error(32'd3);
    drain;
  endtask

  // Reversed bracket collapses the span to zero; a zero search total flags every move
  task automatic test_reversed_bracket;
    apply_setting(32'hFFFF_FFFF, 32'd0, 32'd0, 16'd0);
    send_error(32'd1);
    send_error(32'd0);
    send_error(32'd0);
    send_error(32'd2);
    drain;
  endtask

  // Bracket writes mid-search take effect only at the next search; stop gap at once
  task automatic test_midsearch_writes;
    apply_setting(32'd0, 32'd1000, 32'd0, 16'd1);
    send_error(32'd100);
    send_error(32'd100);
    drain;
    reg_write(REG_STEP_LOW, 32'd500);
    reg_write(REG_STEP_HIGH, 32'd600);
    send_error(32'd10);
    drain;
    reg_write(REG_STOP_GAP, 32'hFFFF_FFFF);
    send_error(32'd20);
    send_error(32'd0);
    drain;
  endtask

  function automatic logic [15:0] pick_total;
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'($urandom_range(2, 3));
      3: return 16'($urandom_range(1, 20));
      4: return 16'hFFFF;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // Phases of random searches, each under its own register setting
  task automatic test_random_searches;
    int          burst_left;
    logic [31:0] lo;
    burst_left = 0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain;
      lo = $urandom;
      case (p % 6)
        0: apply_setting(STEP_LOW_RST, STEP_HIGH_RST, STOP_GAP_RST, pick_total());
        1: apply_setting(32'd0, 32'hFFFF_FFFF, 32'd0, pick_total());
        2: apply_setting($urandom, $urandom, $urandom >> $urandom_range(0, 31), pick_total());
        3: apply_setting(lo, lo + $urandom_range(0, 1 << 20), $urandom_range(0, 255),
                         pick_total());
        4: apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, pick_total());
        default: apply_setting(32'd0, $urandom, $urandom, pick_total());
      endcase
      repeat (ERRORS_PER_PHASE) begin
        // Switch idling on and off in stretches
        if (burst_left == 0) begin
          in_gaps_on = ($urandom_range(0, 3) != 0);
          out_gaps_on = ($urandom_range(0, 3) != 0);
          burst_left = $urandom_range(10, 60);
        end
        burst_left--;
        send_error(measured_at((srch_phase == PH_WAIT_A) ? cfg_step_low : probe_at));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_measured_error = 32'd0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 4'd0;
    pwdata = 32'd0;
    cycles = 0;
    mismatches = 0;
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
    cfg_step_low = STEP_LOW_RST;
    cfg_step_high = STEP_HIGH_RST;
    cfg_stop_gap = STOP_GAP_RST;
    cfg_search_total = SEARCH_TOTAL_RST;
    srch_phase = PH_WAIT_A;
    refining = 1'b0;
    {a_step, b_step, c_step, d_step} = '0;
    {a_err, b_err, c_err, d_err} = '0;
    searches_done = 16'd0;
    probe_at = 32'd0;
    // The random phases may join a search already under way: start from a defined curve
    err_style = 0;
    bowl_centre = 32'd0;
    bowl_shift = 0;
    flat_err = 32'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_reset();
    test_four_point_searches();
    test_reversed_bracket();
    test_midsearch_writes();
    test_random_searches();

    // Wait out the last results, then catch any stray one
    drain;
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
